### rtl/core/macd_indicator_unit_defines.svh
// Assertion macros for the MACD indicator block.
// Included by files that carry concurrent checks; expects clk and rst in scope.
`ifndef MACD_INDICATOR_UNIT_DEFINES_SVH
`define MACD_INDICATOR_UNIT_DEFINES_SVH

// same-cycle implication, inactive during reset
`define MACD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, inactive during reset
`define MACD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/macd_pkg.sv
// Shared types and constants for the MACD indicator block.
// No dependencies; imported by macd_mac_unit and macd_indicator_unit.
package macd_pkg;

  localparam int PRICE_BITS       = 32;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WEIGHT_BITS      = WEIGHT_FRAC_BITS + 1;
  localparam int CFG_INDEX_BITS   = 2;

  // arithmetic widths of the shared unit
  localparam int DIFF_W   = PRICE_BITS + 1;
  localparam int PROD_W   = DIFF_W + WEIGHT_BITS + 1;
  localparam int SCALED_W = PROD_W - WEIGHT_FRAC_BITS;
  localparam int SUM_W    = SCALED_W + 1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_FAST_WEIGHT   = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOW_WEIGHT   = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SIGNAL_WEIGHT = CFG_INDEX_BITS'(2);

  localparam logic [WEIGHT_BITS-1:0] FAST_WEIGHT_RESET   = WEIGHT_BITS'(10082);
  localparam logic [WEIGHT_BITS-1:0] SLOW_WEIGHT_RESET   = WEIGHT_BITS'(4855);
  localparam logic [WEIGHT_BITS-1:0] SIGNAL_WEIGHT_RESET = WEIGHT_BITS'(13107);

  typedef struct packed {
    logic signed [PRICE_BITS-1:0] price;
    logic                         price_present;
  } macd_in_t;

  typedef struct packed {
    logic                         result_valid;
    logic signed [PRICE_BITS-1:0] fast_average;
    logic signed [PRICE_BITS-1:0] slow_average;
    logic signed [PRICE_BITS-1:0] macd_line;
    logic signed [PRICE_BITS-1:0] signal_line;
    logic signed [PRICE_BITS-1:0] histogram;
  } macd_out_t;

  // control of the shared multiply / add unit
  typedef struct packed {
    logic mul_en;   // load product register
    logic add_sub;  // adder computes a - b instead of a + scaled product
  } macd_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_FAST,
    S_MUL_SLOW,
    S_ADD_SLOW,
    S_MACD,
    S_MUL_SIG,
    S_ADD_SIG,
    S_DONE
  } macd_state_t;

endpackage

### rtl/core/macd_mac_unit.sv
// Shared arithmetic unit: registered (a - b) * weight, plus a saturating adder.
// Depends on macd_pkg.
module macd_mac_unit
  import macd_pkg::*;
(
  input  logic                          clk,
  input  macd_ctl_t                     ctl,
  input  logic signed [PRICE_BITS-1:0]  mul_a,
  input  logic signed [PRICE_BITS-1:0]  mul_b,
  input  logic        [WEIGHT_BITS-1:0] mul_w,
  input  logic signed [PRICE_BITS-1:0]  add_a,
  input  logic signed [PRICE_BITS-1:0]  add_b,
  output logic signed [PRICE_BITS-1:0]  sum
);

  logic signed [DIFF_W-1:0]        diff;
  logic signed [WEIGHT_BITS:0]     w_ext;
  logic signed [PROD_W-1:0]        prod;
  logic signed [SCALED_W-1:0]      scaled;
  logic signed [SUM_W-1:0]         a_ext;
  logic signed [SUM_W-1:0]         b_ext;
  logic signed [SUM_W-1:0]         operand;
  logic signed [SUM_W-1:0]         raw;
  logic [SUM_W-PRICE_BITS:0]       top_bits;

  assign diff  = DIFF_W'(mul_a) - DIFF_W'(mul_b);
  assign w_ext = $signed({1'b0, mul_w});

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= PROD_W'(diff) * PROD_W'(w_ext);
    end
  end

  // dropping the fraction bits of a signed product floors it
  assign scaled  = prod[PROD_W-1:WEIGHT_FRAC_BITS];
  assign a_ext   = SUM_W'(add_a);
  assign b_ext   = SUM_W'(add_b);
  assign operand = ctl.add_sub ? -b_ext : SUM_W'(scaled);
  assign raw     = a_ext + operand;

  // in range when all bits above the price sign agree with it
  assign top_bits = raw[SUM_W-1:PRICE_BITS-1];

  always_comb begin
    if (top_bits == '0 || top_bits == '1) begin
      sum = raw[PRICE_BITS-1:0];
    end else if (raw[SUM_W-1]) begin
      sum = {1'b1, {(PRICE_BITS-1){1'b0}}};
    end else begin
      sum = {1'b0, {(PRICE_BITS-1){1'b1}}};
    end
  end

endmodule

### rtl/core/macd_indicator_unit.sv
// MACD indicator: one price sample in, one result out per transfer. A seeded
// sample steps through S_MUL_FAST, S_MUL_SLOW, S_ADD_SLOW, S_MACD, S_MUL_SIG,
// S_ADD_SIG and S_DONE, which loads the output register; no new sample is taken
// until the sequencer is back in S_IDLE, because the three averages share one
// multiplier and one saturating adder and are chained fast, slow, signal. The
// first valid price, and any missing price before it, go from S_IDLE straight
// to S_DONE. While a result waits on out_ready the sequencer holds in its last
// state. A new sample is taken while the previous result still waits in the
// output register. Weights are written through cfg_write/cfg_index/cfg_data;
// the user must do so only while idle, the block itself does not enforce it.
// Depends on macd_pkg, macd_mac_unit and macd_indicator_unit_defines.svh.
`include "macd_indicator_unit_defines.svh"

module macd_indicator_unit
  import macd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  macd_in_t                      in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output macd_out_t                     out_data,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [WEIGHT_BITS-1:0]        cfg_data
);

  macd_state_t state, state_next;

  logic [WEIGHT_BITS-1:0]       fast_weight, slow_weight, signal_weight;
  logic signed [PRICE_BITS-1:0] x, fast_acc, slow_acc, signal_acc, held_price, macd;
  logic                         seeded, item_ok;

  macd_ctl_t                    ctl;
  logic signed [PRICE_BITS-1:0] mul_a, mul_b, add_a, add_b, sum;
  logic [WEIGHT_BITS-1:0]       mul_w;
  logic signed [PRICE_BITS-1:0] x_in;
  logic                         in_xfer, out_load;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);
  assign x_in     = in_data.price_present ? in_data.price : held_price;

  macd_mac_unit u_mac (
    .clk   (clk),
    .ctl   (ctl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_w (mul_w),
    .add_a (add_a),
    .add_b (add_b),
    .sum   (sum)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = seeded ? S_MUL_FAST : S_DONE;
        end
      end
      S_MUL_FAST: state_next = S_MUL_SLOW;
      S_MUL_SLOW: state_next = S_ADD_SLOW;
      S_ADD_SLOW: state_next = S_MACD;
      S_MACD:     state_next = S_MUL_SIG;
      S_MUL_SIG:  state_next = S_ADD_SIG;
      S_ADD_SIG:  state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    ctl   = '0;
    mul_a = x;
    mul_b = fast_acc;
    mul_w = fast_weight;
    add_a = fast_acc;
    add_b = slow_acc;
    case (state)
      S_MUL_FAST: begin
        ctl.mul_en = 1'b1;
      end
      S_MUL_SLOW: begin
        ctl.mul_en = 1'b1;
        mul_b      = slow_acc;
        mul_w      = slow_weight;
      end
      S_ADD_SLOW: begin
        add_a = slow_acc;
      end
      S_MACD: begin
        ctl.add_sub = 1'b1;
      end
      S_MUL_SIG: begin
        ctl.mul_en = 1'b1;
        mul_a      = macd;
        mul_b      = signal_acc;
        mul_w      = signal_weight;
      end
      S_ADD_SIG: begin
        add_a = signal_acc;
      end
      S_DONE: begin
        ctl.add_sub = 1'b1;
        add_a       = macd;
        add_b       = signal_acc;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      seeded        <= 1'b0;
      out_valid     <= 1'b0;
      fast_weight   <= FAST_WEIGHT_RESET;
      slow_weight   <= SLOW_WEIGHT_RESET;
      signal_weight <= SIGNAL_WEIGHT_RESET;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_FAST_WEIGHT:   fast_weight   <= cfg_data;
          CFG_SLOW_WEIGHT:   slow_weight   <= cfg_data;
          CFG_SIGNAL_WEIGHT: signal_weight <= cfg_data;
          default: ;
        endcase
      end
      if (in_xfer && in_data.price_present) begin
        seeded <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          x       <= x_in;
          item_ok <= seeded || in_data.price_present;
          if (seeded || in_data.price_present) begin
            held_price <= x_in;
          end
          if (!seeded && in_data.price_present) begin
            fast_acc   <= in_data.price;
            slow_acc   <= in_data.price;
            signal_acc <= '0;
            macd       <= '0;
          end
        end
      end
      S_MUL_SLOW: fast_acc   <= sum;
      S_ADD_SLOW: slow_acc   <= sum;
      S_MACD:     macd       <= sum;
      S_ADD_SIG:  signal_acc <= sum;
      S_DONE: begin
        if (out_load) begin
          if (item_ok) begin
            out_data.result_valid <= 1'b1;
            out_data.fast_average <= fast_acc;
            out_data.slow_average <= slow_acc;
            out_data.macd_line    <= macd;
            out_data.signal_line  <= signal_acc;
            out_data.histogram    <= sum;
          end else begin
            out_data <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  `MACD_ASSERT_NOW(a_invalid_zero, out_valid && !out_data.result_valid, out_data.fast_average == 0 && out_data.macd_line == 0 && out_data.histogram == 0, "invalid result carries nonzero data")
  `MACD_ASSERT_NOW(a_valid_needs_seed, out_valid && out_data.result_valid, seeded, "valid result before seeding")
  `MACD_ASSERT_NEXT(a_seed_sticky, seeded, seeded, "seeded flag dropped")
  `MACD_ASSERT_NEXT(a_seeded_runs, in_xfer && seeded, state == S_MUL_FAST, "seeded sample skipped the averaging sequence")

endmodule

### tb/sv/macd_indicator_unit_tb.sv
// Self-checking testbench for macd_indicator_unit: price bars in, indicator bars out.
// A bit-accurate MACD predictor class checks every output transfer in order.
// Depends on macd_pkg and the macd_indicator_unit RTL.
module macd_indicator_unit_tb;
  import macd_pkg::*;

  localparam longint PRICE_MAX = (longint'(1) <<< (PRICE_BITS - 1)) - 1;
  localparam longint PRICE_MIN = -PRICE_MAX - 1;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1 << WEIGHT_FRAC_BITS);
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_TOP = '1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = '1;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 12;

  class macd_predictor;
    logic [WEIGHT_BITS-1:0] fast_w, slow_w, sig_w;
    longint fast_acc, slow_acc, sig_acc, last_price;
    bit seeded;
    macd_out_t pending_bars[$];
    int unsigned errors;

    function new();
      fast_w = FAST_WEIGHT_RESET;
      slow_w = SLOW_WEIGHT_RESET;
      sig_w = SIGNAL_WEIGHT_RESET;
      fast_acc = 0;
      slow_acc = 0;
      sig_acc = 0;
      last_price = 0;
      seeded = 1'b0;
      errors = 0;
    endfunction

    function longint clamp(longint v);
      if (v > PRICE_MAX) return PRICE_MAX;
      if (v < PRICE_MIN) return PRICE_MIN;
      return v;
    endfunction

    // exact product, then arithmetic shift = floor toward minus infinity
    function longint ema_step(longint acc, longint x, logic [WEIGHT_BITS-1:0] w);
      longint wl;
      wl = longint'(w);
      return clamp(acc + (((x - acc) * wl) >>> WEIGHT_FRAC_BITS));
    endfunction

    function void set_weight(logic [CFG_INDEX_BITS-1:0] idx, logic [WEIGHT_BITS-1:0] v);
      case (idx)
        CFG_FAST_WEIGHT: fast_w = v;
        CFG_SLOW_WEIGHT: slow_w = v;
        CFG_SIGNAL_WEIGHT: sig_w = v;
        default: ;
      endcase
    endfunction

    function void take_price(macd_in_t item);
      macd_out_t bar;
      longint x, macd, hist;
      bar = '0;
      // nothing seen yet: invalid all-zero bar, state untouched
      if (!seeded && !item.price_present) begin
        pending_bars = {pending_bars, bar};
        return;
      end
      if (item.price_present) x = longint'($signed(item.price));
      else x = last_price;
      if (!seeded) begin
        fast_acc = x;
        slow_acc = x;
        sig_acc = 0;
        macd = 0;
        seeded = 1'b1;
      end else begin
        fast_acc = ema_step(fast_acc, x, fast_w);
        slow_acc = ema_step(slow_acc, x, slow_w);
        macd = clamp(fast_acc - slow_acc);
        sig_acc = ema_step(sig_acc, macd, sig_w);
      end
      last_price = x;
      hist = clamp(macd - sig_acc);
      bar.result_valid = 1'b1;
      bar.fast_average = PRICE_BITS'(fast_acc);
      bar.slow_average = PRICE_BITS'(slow_acc);
      bar.macd_line = PRICE_BITS'(macd);
      bar.signal_line = PRICE_BITS'(sig_acc);
      bar.histogram = PRICE_BITS'(hist);
      pending_bars = {pending_bars, bar};
    endfunction

    function void check_field(string name, logic [PRICE_BITS-1:0] want,
                              logic [PRICE_BITS-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
        errors++;
      end
    endfunction

    function void check_bar(macd_out_t got);
      macd_out_t want;
      if (pending_bars.size() == 0) begin
        $error("output transfer with no expected bar pending");
        errors++;
        return;
      end
      want = pending_bars.pop_front();
      check_field("result_valid", PRICE_BITS'(want.result_valid),
                  PRICE_BITS'(got.result_valid));
      check_field("fast_average", want.fast_average, got.fast_average);
      check_field("slow_average", want.slow_average, got.slow_average);
      check_field("macd_line", want.macd_line, got.macd_line);
      check_field("signal_line", want.signal_line, got.signal_line);
      check_field("histogram", want.histogram, got.histogram);
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  macd_in_t in_data;
  macd_out_t out_data;
  logic cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [WEIGHT_BITS-1:0] cfg_data;

  macd_predictor tracker = new();
  macd_in_t stim_q[$];
  longint walk_price = 0;
  bit sink_gaps = 1'b1;
  int unsigned sink_hold = 0;

  macd_indicator_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic macd_in_t mk_bar(longint p, bit present);
    macd_in_t b;
    b.price = PRICE_BITS'(p);
    b.price_present = present;
    return b;
  endfunction

  function automatic void queue_bar(macd_in_t b);
    stim_q = {stim_q, b};
  endfunction

  function automatic macd_in_t random_bar();
    int unsigned r;
    longint p;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      walk_price = longint'($signed($urandom()));
      p = walk_price;
    end else if (r < 63) begin
      walk_price = walk_price + longint'($urandom_range(0, 4000)) - 2000;
      if (walk_price > PRICE_MAX) walk_price = PRICE_MAX;
      if (walk_price < PRICE_MIN) walk_price = PRICE_MIN;
      p = walk_price;
    end else if (r < 88) begin
      p = longint'($signed($urandom()));
    end else begin
      case ($urandom_range(0, 3))
        0: p = PRICE_MAX;
        1: p = PRICE_MIN;
        2: p = 0;
        default: p = -1;
      endcase
    end
    return mk_bar(p, $urandom_range(0, 99) < 88);
  endfunction

  // mostly realistic 2/(period+1) weights, sometimes anything the register holds
  function automatic logic [WEIGHT_BITS-1:0] pick_weight();
    if ($urandom_range(0, 3) != 0) return WEIGHT_BITS'(131072 / $urandom_range(3, 61));
    return WEIGHT_BITS'($urandom_range(0, (1 << WEIGHT_BITS) - 1));
  endfunction

  task automatic play_bars(input bit with_gaps);
    int unsigned gap;
    for (int i = 0; i < stim_q.size(); i++) begin
      gap = (with_gaps && $urandom_range(0, 99) < 30) ? gap_len() : 0;
      in_valid <= 1'b1;
      in_data <= stim_q[i];
      do @(posedge clk); while (!in_ready);
      tracker.take_price(stim_q[i]);
      if (gap != 0 || i == stim_q.size() - 1) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    // keeps the drop of valid apart from the next burst
    @(posedge clk);
    stim_q.delete();
  endtask

  task automatic run_random(input int n, input bit with_gaps);
    repeat (n) queue_bar(random_bar());
    play_bars(with_gaps);
  endtask

  task automatic settle();
    while (tracker.pending_bars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [WEIGHT_BITS-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    tracker.set_weight(idx, v);
  endtask

  // the unused index gets a write too; it must not disturb anything
  task automatic write_weights(input logic [WEIGHT_BITS-1:0] fw, sw, gw);
    write_reg(CFG_FAST_WEIGHT, fw);
    write_reg(CFG_SLOW_WEIGHT, sw);
    write_reg(CFG_SIGNAL_WEIGHT, gw);
    write_reg(CFG_UNUSED, WEIGHT_BITS'($urandom()));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // missing bars before any price, seeding, held price, full-scale swings
    queue_bar(mk_bar(PRICE_MAX, 1'b0));
    queue_bar(mk_bar(PRICE_MIN, 1'b0));
    queue_bar(mk_bar(0, 1'b0));
    queue_bar(mk_bar(PRICE_MAX, 1'b1));
    queue_bar(mk_bar(-1, 1'b0));
    queue_bar(mk_bar(PRICE_MIN, 1'b1));
    queue_bar(mk_bar(PRICE_MAX, 1'b1));
    queue_bar(mk_bar(0, 1'b1));
    queue_bar(mk_bar(-1, 1'b1));
    queue_bar(mk_bar(1, 1'b1));
    queue_bar(mk_bar(25600, 1'b1));
    queue_bar(mk_bar(0, 1'b0));
    queue_bar(mk_bar(-25600, 1'b1));
    play_bars(1'b1);

    // unity weights: averages follow the price, ends with both averages at the minimum
    settle();
    write_weights(WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE);
    queue_bar(mk_bar(PRICE_MAX, 1'b1));
    queue_bar(mk_bar(PRICE_MIN, 1'b1));
    queue_bar(mk_bar(0, 1'b0));
    queue_bar(mk_bar(PRICE_MIN, 1'b1));
    play_bars(1'b1);

    // frozen slow average and overshooting signal: macd and histogram saturate
    settle();
    write_weights(WEIGHT_ONE, '0, WEIGHT_TOP);
    queue_bar(mk_bar(PRICE_MAX, 1'b1));
    queue_bar(mk_bar(PRICE_MIN, 1'b1));
    queue_bar(mk_bar(PRICE_MAX, 1'b1));
    queue_bar(mk_bar(0, 1'b0));
    queue_bar(mk_bar(PRICE_MIN, 1'b1));
    queue_bar(mk_bar(PRICE_MAX, 1'b1));
    play_bars(1'b0);

    settle();
    write_weights('0, '0, '0);
    run_random(60, 1'b1);

    settle();
    write_weights(FAST_WEIGHT_RESET, SLOW_WEIGHT_RESET, SIGNAL_WEIGHT_RESET);
    run_random(150, 1'b1);
    sink_gaps = 1'b0;
    run_random(100, 1'b0);
    sink_gaps = 1'b1;
    run_random(150, 1'b1);

    // sink stalls for a long stretch while bars keep coming back to back
    sink_hold = HOLD_CYCLES;
    run_random(150, 1'b0);

    settle();
    write_weights(WEIGHT_TOP, WEIGHT_TOP, WEIGHT_TOP);
    run_random(80, 1'b1);

    repeat (4) begin
      settle();
      write_weights(pick_weight(), pick_weight(), pick_weight());
      run_random(130, 1'b1);
    end

    settle();
    if (tracker.errors == 0) begin
      $display("** macd_indicator_unit: PASSED **");
    end else begin
      $display("** macd_indicator_unit: FAILED **");
    end
    $finish;
  end

  // output side: random back-pressure, plus the one long hold
  initial begin
    int unsigned stall;
    stall = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (sink_hold != 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (sink_gaps && $urandom_range(0, 99) < 25) stall = gap_len();
      end
      @(posedge clk);
      if (out_valid && out_ready) tracker.check_bar(out_data);
    end
  end

  // ends the run when no transfer happens on either side for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("** macd_indicator_unit: FAILED **");
    $finish;
  end

endmodule
